@@ src/sli_pkg.sv @@
// Shared constants, codes and transfer types for the sorted list block.
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic       FUNC_INSERT  = 1'b0;
    localparam logic       FUNC_REMOVE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [CNT_W-1:0]   entry_count;
        logic signed [31:0] smallest;
    } result_t;

    typedef struct packed {
        logic load;
        logic walk;
        logic fin;
        logic rd0;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
    } dp_status_t;

endpackage

@@ src/sorted_list_insert_remove.sv @@
// A transfer loads on start, walks the N entries held, then steps S_FIN, S_RD0, S_OUT with done.
// Nothing to walk (empty table, or insert into a full table): the walk reads no entry.
// One transfer at a time, start is taken only while idle;
// the walk reads one entry per cycle through the single read port of the entry memory.
// Reset empties the table; entry memory is not cleared, only the count is.
// The result is shown for one cycle with done; the receiver cannot stall.
module sorted_list_insert_remove
    import sli_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sli_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    sli_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .status  (status),
        .result  (result)
    );

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transfer");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entry_count <= CNT_W'(CAPACITY)))
        else $error("entry count beyond capacity");
`endif

endmodule

@@ src/sli_datapath.sv @@
// Entry memory, walk pointers and update logic of the sorted list.
module sli_datapath
    import sli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  request_t   request,
    output dp_status_t status,
    output result_t    result
);

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd_data_reg;

    logic signed [31:0] key_reg,      key_next;
    logic               func_reg,     func_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [CNT_W-1:0]   left_reg,     left_next;
    logic [IDX_W-1:0]   ptr_reg,      ptr_next;
    logic               pend_reg,     pend_next;
    logic [IDX_W-1:0]   pend_addr_reg, pend_addr_next;
    logic               placed_reg,   placed_next;
    logic               found_reg,    found_next;
    logic               special_reg,  special_next;
    logic [1:0]         status_reg,   status_next;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic signed [31:0] wdata;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   cnt_dec;

    assign cnt_dec = count_reg - 1'b1;

    always_comb
    begin
        key_next       = key_reg;
        func_next      = func_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        placed_next    = placed_reg;
        found_next     = found_reg;
        special_next   = special_reg;
        status_next    = status_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        if (cmd.load)
        begin
            key_next    = request.value;
            func_next   = request.func;
            placed_next = 1'b0;
            found_next  = 1'b0;
            status_next = ST_OK;
            if (request.func == FUNC_INSERT)
            begin
                special_next = (count_reg == CNT_W'(CAPACITY));
                if (count_reg == CNT_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                left_next = (count_reg == CNT_W'(CAPACITY)) ? '0 : count_reg;
                ptr_next  = cnt_dec[IDX_W-1:0];
            end
            else
            begin
                special_next = (count_reg == '0);
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                left_next = count_reg;
                ptr_next  = '0;
            end
        end

        if (cmd.walk)
        begin
            // process the entry read last cycle
            if (pend_reg)
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    if (!placed_reg)
                    begin
                        we    = 1'b1;
                        waddr = pend_addr_reg + 1'b1;
                        if (rd_data_reg > key_reg)
                        begin
                            wdata = rd_data_reg;
                        end
                        else
                        begin
                            wdata       = key_reg;
                            placed_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        we    = 1'b1;
                        waddr = pend_addr_reg - 1'b1;
                        wdata = rd_data_reg;
                    end
                    else if (rd_data_reg == key_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
            end
            // insert walks down from the top, remove walks up from the bottom
            if (left_reg != '0)
            begin
                rd_en          = 1'b1;
                rd_addr        = ptr_reg;
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg;
                left_next      = left_reg - 1'b1;
                ptr_next       = (func_reg == FUNC_INSERT) ? ptr_reg - 1'b1
                                                           : ptr_reg + 1'b1;
            end
        end

        if (cmd.fin && !special_reg)
        begin
            if (func_reg == FUNC_INSERT)
            begin
                if (!placed_reg)
                begin
                    we    = 1'b1;
                    waddr = '0;
                    wdata = key_reg;
                end
                count_next = count_reg + 1'b1;
            end
            else if (found_reg)
            begin
                count_next = count_reg - 1'b1;
            end
            else
            begin
                status_next = ST_NOT_FOUND;
            end
        end

        if (cmd.rd0)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            left_reg    <= '0;
            pend_reg    <= 1'b0;
            placed_reg  <= 1'b0;
            found_reg   <= 1'b0;
            special_reg <= 1'b0;
            status_reg  <= ST_OK;
            func_reg    <= FUNC_INSERT;
        end
        else
        begin
            count_reg   <= count_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            placed_reg  <= placed_next;
            found_reg   <= found_next;
            special_reg <= special_next;
            status_reg  <= status_next;
            func_reg    <= func_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign status.walk_done   = (left_reg == '0) && !pend_reg;
    assign result.status      = status_reg;
    assign result.entry_count = count_reg;
    assign result.smallest    = (count_reg == '0) ? 32'sd0 : rd_data_reg;

endmodule

@@ src/sli_ctrl.sv @@
// Sequencer that steps the datapath through one transfer.
module sli_ctrl
    import sli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_RD0  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:   state_next = S_RD0;
            S_RD0:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.load = (state_reg == S_IDLE) && start;
    assign cmd.walk = (state_reg == S_WALK);
    assign cmd.fin  = (state_reg == S_FIN);
    assign cmd.rd0  = (state_reg == S_RD0);
    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_OUT);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sorted list block: corner cases, then random traffic.
module tb_top;
    import sli_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int PHASE_ITEMS    = 575;

    class sorted_table_scoreboard;
        int      shadow_entries[$];   // ascending copy of the table
        result_t pending_results[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        function void note_request(input request_t req);
            result_t exp;
            int      pos;
            int      v;
            v = req.value;
            exp.status = ST_OK;
            if (req.func == FUNC_INSERT)
            begin
                if (shadow_entries.size() >= CAPACITY)
                    exp.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < shadow_entries.size() && shadow_entries[pos] < v)
                        pos++;
                    shadow_entries.insert(pos, v);
                end
            end
            else if (shadow_entries.size() == 0)
                exp.status = ST_EMPTY;
            else
            begin
                pos = 0;
                while (pos < shadow_entries.size() && shadow_entries[pos] != v)
                    pos++;
                if (pos == shadow_entries.size())
                    exp.status = ST_NOT_FOUND;
                else
                    shadow_entries.delete(pos);
            end
            exp.entry_count = CNT_W'(shadow_entries.size());
            exp.smallest    = (shadow_entries.size() != 0) ? shadow_entries[0] : 0;
            pending_results.push_back(exp);
        endfunction

        task check_result(input result_t got);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d count=%0d smallest=%0d",
                                 got.status, got.entry_count, got.smallest));
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status)
                report($sformatf("status got %0d exp %0d", got.status, exp.status));
            if (got.entry_count !== exp.entry_count)
                report($sformatf("entry_count got %0d exp %0d",
                                 got.entry_count, exp.entry_count));
            if (got.smallest !== exp.smallest)
                report($sformatf("smallest got %0d exp %0d", got.smallest, exp.smallest));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    sorted_table_scoreboard sb = new();
    int idle_cycles = 0;
    int inserted_values[$];

    sorted_list_insert_remove dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #10 clk = ~clk;

    // transfer monitor: requests feed the predictor, results are checked in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(request);
            if (done)
                sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send(input logic f, input int v, input int idle_pct);
        request_t req;
        int       gap;
        req.func  = f;
        req.value = v;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 24);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic int pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return int'($urandom_range(8)) - 4;
        if (sel < 60)
        begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh8000_0001;
                default: return 32'sh7FFF_FFFE;
            endcase
        end
        return int'($urandom);
    endfunction

    task automatic random_item(input int insert_pct, input int idle_pct);
        int v;
        if ($urandom_range(99) < insert_pct)
        begin
            v = pick_value();
            inserted_values.push_back(v);
            if (inserted_values.size() > 32)
                void'(inserted_values.pop_front());
            send(FUNC_INSERT, v, idle_pct);
        end
        else
        begin
            if (inserted_values.size() != 0 && $urandom_range(99) < 70)
                v = inserted_values[$urandom_range(inserted_values.size() - 1)];
            else
                v = pick_value();
            send(FUNC_REMOVE, v, idle_pct);
        end
    endtask

    initial
    begin
        int idle_pcts[3];
        int bias[3];
        idle_pcts = '{0, 45, 21};
        bias      = '{80, 20, 50};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then the only entry going away
        send(FUNC_REMOVE, 7, 0);
        send(FUNC_INSERT, 7, 0);
        send(FUNC_REMOVE, 7, 0);
        send(FUNC_REMOVE, 7, 0);
        // extremes, duplicate, miss, smallest removal
        send(FUNC_INSERT, 32'sh7FFF_FFFF, 0);
        send(FUNC_INSERT, 32'sh8000_0000, 0);
        send(FUNC_INSERT, 0, 0);
        send(FUNC_INSERT, -1, 0);
        send(FUNC_INSERT, 0, 0);
        send(FUNC_REMOVE, 5, 0);
        send(FUNC_REMOVE, 32'sh8000_0000, 0);
        send(FUNC_REMOVE, 0, 0);
        // fill to capacity, then one more
        repeat (CAPACITY - 3)
            send(FUNC_INSERT, int'($urandom), 0);
        send(FUNC_INSERT, 32'sh5555_AAAA, 0);

        for (int p = 0; p < 3; p++)
        begin
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item(bias[(i / 40) % 3], idle_pcts[p]);
        end
        start <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
